// ===== design/hmpp_pkg.sv =====
// shared types and codes for the perturbation-probed hash table
`timescale 1ns / 1ps
`default_nettype none

package hmpp_pkg;

  localparam int MAX_SLOTS_LOG2_DEF = 10;
  localparam int CFG_W              = 4;
  localparam int OUT_CNT_W          = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

  // commands
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  // result status
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_CHANGED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // slot marks
  localparam logic [1:0] MARK_UNUSED  = 2'd0;
  localparam logic [1:0] MARK_DELETED = 2'd1;
  localparam logic [1:0] MARK_VALID   = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [63:0]          result_value;
    logic [OUT_CNT_W-1:0] entries_used;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mark;
    logic [63:0] key;
    logic [63:0] value;
  } slot_entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== design/hmpp_slot_ram.sv =====
// single-port slot memory holding mark, key and value, registered read
`timescale 1ns / 1ps
`default_nettype none

module hmpp_slot_ram
  import hmpp_pkg::*;
#(
  parameter int ADDR_W = MAX_SLOTS_LOG2_DEF
) (
  input  wire logic        clk,
  input  wire mem_ctl_t    ctl,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire slot_entry_t wdata,
  output slot_entry_t      rdata
);

  slot_entry_t mem [2**ADDR_W];
  slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/hash_map_perturb_probe_unit.sv =====
// hash table top: command sequencer probing a slot memory with a registered read
// each slot probed is a memory read state (S_PROBE) plus an evaluate state (S_EVAL);
//   codes 5..7 skip the probing and go straight to the result state
// one command at a time: in_stall is high until the result is issued, and the result waits while out_stall holds
// reset: a clearing pass writes every slot unused, with in_stall high;
//   counters clear and table_size_log2 returns to 10
`timescale 1ns / 1ps
`default_nettype none

module hash_map_perturb_probe_unit
  import hmpp_pkg::*;
#(
  parameter int MAX_SLOTS_LOG2 = MAX_SLOTS_LOG2_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item
);

  localparam int AW  = MAX_SLOTS_LOG2;
  localparam int NW  = AW + 1;
  localparam int UW  = AW + 2;
  localparam int CW  = AW + 5;
  localparam int LGW = $clog2(AW + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r, cfg_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [63:0]      key_r, key_nxt;
  logic [63:0]      val_r, val_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [63:0]      perturb_r, perturb_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             tomb_seen_r, tomb_seen_nxt;
  logic [AW-1:0]    tomb_r, tomb_nxt;
  logic             found_r, found_nxt;
  logic             have_free_r, have_free_nxt;
  logic             fs_tomb_r, fs_tomb_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic [NW-1:0]    used_r, used_nxt;
  logic [NW-1:0]    tcnt_r, tcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_addr;
  slot_entry_t      mem_wdata;
  slot_entry_t      rd;

  logic [LGW-1:0]   lg_eff;
  logic [AW-1:0]    mask;
  logic [NW-1:0]    size;
  logic [CW-1:0]    limit;
  logic [AW-1:0]    idx_step;
  logic             key_hit;
  logic             slot_open;
  logic             last_probe;
  logic             out_free;
  logic [UW-1:0]    fill;
  logic [UW-1:0]    fill_scaled;
  logic [63:0]      sum_val;

  hmpp_slot_ram #(
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd)
  );

  // effective size: 0 acts as 1, above max clamps to max
  always_comb begin
    if (cfg_r == '0) begin
      lg_eff = LGW'(1);
    end else if (int'(cfg_r) > AW) begin
      lg_eff = LGW'(AW);
    end else begin
      lg_eff = LGW'(cfg_r);
    end
  end

  assign mask       = ~({AW{1'b1}} << lg_eff);
  assign size       = NW'(1) << lg_eff;
  assign limit      = CW'(size) + CW'(16);
  assign idx_step   = ((idx_r << 2) + idx_r + AW'(1) + perturb_r[AW-1:0]) & mask;
  assign key_hit    = (rd.mark == MARK_VALID) && (rd.key == key_r);
  assign slot_open  = (rd.mark != MARK_VALID);
  assign last_probe = ((cnt_r + CW'(1)) == limit);
  assign out_free   = !out_valid_r || !out_stall;
  assign fill       = UW'(used_r) + UW'(tcnt_r);
  assign fill_scaled = fill + (fill >> 1);
  assign sum_val    = rd.value + val_r;

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    perturb_nxt   = perturb_r;
    cnt_nxt       = cnt_r;
    tomb_seen_nxt = tomb_seen_r;
    tomb_nxt      = tomb_r;
    found_nxt     = found_r;
    have_free_nxt = have_free_r;
    fs_tomb_nxt   = fs_tomb_r;
    tgt_nxt       = tgt_r;
    used_nxt      = used_r;
    tcnt_nxt      = tcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    mem_ctl       = '0;
    mem_addr      = tgt_r;
    mem_wdata     = rd;

    case (state_r)
      S_CLEAR: begin
        mem_ctl.we = 1'b1;
        mem_addr   = clr_r;
        mem_wdata  = '0;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = in_item.cmd;
          key_nxt       = in_item.key;
          val_nxt       = in_item.value;
          idx_nxt       = in_item.key[AW-1:0] & mask;
          perturb_nxt   = in_item.key;
          cnt_nxt       = '0;
          tomb_seen_nxt = 1'b0;
          found_nxt     = 1'b0;
          have_free_nxt = 1'b0;
          fs_tomb_nxt   = 1'b0;
          // unknown codes skip the search and answer not found
          state_nxt     = (in_item.cmd > CMD_DELETE) ? S_ACT : S_PROBE;
        end
      end

      S_PROBE: begin
        mem_ctl.re = 1'b1;
        mem_addr   = idx_r;
        state_nxt  = S_EVAL;
      end

      S_EVAL: begin
        if (rd.mark == MARK_UNUSED) begin
          found_nxt     = 1'b0;
          have_free_nxt = 1'b1;
          fs_tomb_nxt   = tomb_seen_r;
          tgt_nxt       = tomb_seen_r ? tomb_r : idx_r;
          state_nxt     = S_ACT;
        end else if (key_hit) begin
          found_nxt = 1'b1;
          tgt_nxt   = idx_r;
          state_nxt = S_ACT;
        end else begin
          if (slot_open && !tomb_seen_r) begin
            tomb_seen_nxt = 1'b1;
            tomb_nxt      = idx_r;
          end
          if (last_probe) begin
            // probe limit (size + 16 probes) reached without an unused slot
            found_nxt     = 1'b0;
            have_free_nxt = tomb_seen_r || slot_open;
            fs_tomb_nxt   = 1'b1;
            tgt_nxt       = tomb_seen_r ? tomb_r : idx_r;
            state_nxt     = S_ACT;
          end else begin
            cnt_nxt     = cnt_r + CW'(1);
            idx_nxt     = idx_step;
            perturb_nxt = perturb_r >> 5;
            state_nxt   = S_PROBE;
          end
        end
      end

      S_ACT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = ST_NOT_FOUND;
          out_item_nxt.result_value = '0;
          if (cmd_r <= CMD_UPDATE && found_r) begin
            mem_ctl.we      = 1'b1;
            mem_wdata.value = (cmd_r == CMD_ADD) ? sum_val : val_r;
            out_item_nxt.status       = ST_CHANGED;
            out_item_nxt.result_value = mem_wdata.value;
          end else if (cmd_r <= CMD_ADD) begin
            if (fill_scaled >= UW'(size) || !have_free_r) begin
              out_item_nxt.status = ST_FULL;
            end else begin
              mem_ctl.we      = 1'b1;
              mem_wdata.mark  = MARK_VALID;
              mem_wdata.key   = key_r;
              mem_wdata.value = val_r;
              if (fs_tomb_r && tcnt_r != '0) begin
                tcnt_nxt = tcnt_r - NW'(1);
              end
              used_nxt = used_r + NW'(1);
              out_item_nxt.status       = ST_INSERTED;
              out_item_nxt.result_value = val_r;
            end
          end else if (cmd_r == CMD_LOOKUP && found_r) begin
            out_item_nxt.status       = ST_FOUND;
            out_item_nxt.result_value = rd.value;
          end else if (cmd_r == CMD_DELETE && found_r) begin
            mem_ctl.we     = 1'b1;
            mem_wdata.mark = MARK_DELETED;
            if (used_r != '0) begin
              used_nxt = used_r - NW'(1);
            end
            tcnt_nxt = tcnt_r + NW'(1);
            out_item_nxt.status = ST_DELETED;
          end
          out_item_nxt.entries_used = OUT_CNT_W'(used_nxt);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_r       <= CFG_RESET;
      clr_r       <= '0;
      used_r      <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    perturb_r   <= perturb_nxt;
    cnt_r       <= cnt_nxt;
    tomb_seen_r <= tomb_seen_nxt;
    tomb_r      <= tomb_nxt;
    found_r     <= found_nxt;
    have_free_r <= have_free_nxt;
    fs_tomb_r   <= fs_tomb_nxt;
    tgt_r       <= tgt_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
